>>> rtl/smbt_pkg.sv
// Shared types and constants for the SPI master byte transceiver.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none
package smbt_pkg;

  localparam int unsigned BITS_PER_BYTE  = 8;
  localparam int unsigned HALF_CNT       = 2 * BITS_PER_BYTE;
  localparam int unsigned HALF_W         = $clog2(HALF_CNT);
  localparam int unsigned DIV_W          = 19;
  localparam int unsigned TMO_W          = 16;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 19;
  localparam int unsigned TICKS_PER_MS_D = 1000;
  localparam logic [7:0]  TX_FILL        = 8'hFF;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;
  localparam logic [TMO_W-1:0] MS_MAX    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] tx_byte;
    logic       tx_present;
    logic       first_byte;
    logic       last_byte;
    logic       miso;
  } in_item_t;

  typedef struct packed {
    logic             sck;
    logic             mosi;
    logic [7:0]       rx_byte;
    logic             rx_valid;
    logic             transfer_done;
    logic             timed_out;
    logic             busy_res;
    logic             load_rejected;
    logic [CNT_W-1:0] transfers;
    logic [CNT_W-1:0] errors;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       spi_mode;
    logic [DIV_W-1:0] half_period_ticks;
    logic [TMO_W-1:0] abort_ms;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/smbt_if.sv
// Valid/ready channel interfaces for the transceiver's item and result streams.
// Depends on smbt_pkg for field widths.
`default_nettype none
interface smbt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] tx_byte;
  logic       tx_present;
  logic       first_byte;
  logic       last_byte;
  logic       miso;

  modport source (output valid, mode, tx_byte, tx_present, first_byte, last_byte, miso,
                  input ready);
  modport sink   (input valid, mode, tx_byte, tx_present, first_byte, last_byte, miso,
                  output ready);
endinterface

interface smbt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sck;
  logic                        mosi;
  logic [7:0]                  rx_byte;
  logic                        rx_valid;
  logic                        transfer_done;
  logic                        timed_out;
  logic                        busy_res;
  logic                        load_rejected;
  logic [smbt_pkg::CNT_W-1:0]  transfers;
  logic [smbt_pkg::CNT_W-1:0]  errors;

  modport source (output valid, sck, mosi, rx_byte, rx_valid, transfer_done, timed_out,
                  busy_res, load_rejected, transfers, errors,
                  input ready);
  modport sink   (input valid, sck, mosi, rx_byte, rx_valid, transfer_done, timed_out,
                  busy_res, load_rejected, transfers, errors,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/smbt_core.sv
// Transceiver state and per-item update: divider, shifters, timer, counters.
// Depends on smbt_pkg; instantiated by the top level.
`default_nettype none
module smbt_core #(
  parameter int unsigned TICKS_PER_MS = smbt_pkg::TICKS_PER_MS_D
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  smbt_pkg::in_item_t   item,
  input  smbt_pkg::cfg_t       cfg,
  output smbt_pkg::out_item_t  res
);
  import smbt_pkg::*;

  localparam int unsigned SUB_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam logic [SUB_W:0] SUB_LIM = (SUB_W + 1)'(TICKS_PER_MS);

  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;
  logic [7:0]        sout_r, sout_nxt;
  logic [7:0]        sin_r, sin_nxt;
  logic              shifting_r, shifting_nxt;
  logic              clk_lvl_r, clk_lvl_nxt;
  logic              dat_lvl_r, dat_lvl_nxt;
  logic              ending_r, ending_nxt;
  logic              aborted_r, aborted_nxt;
  logic [SUB_W-1:0]  sub_r, sub_nxt;
  logic [TMO_W-1:0]  ms_r, ms_nxt;
  logic [CNT_W-1:0]  xfers_r, xfers_nxt;
  logic [CNT_W-1:0]  errs_r, errs_nxt;

  logic              idle_lvl;
  logic              phase1;
  logic [DIV_W:0]    limit;
  logic [DIV_W:0]    div_inc;
  logic [SUB_W:0]    sub_inc;
  logic [HALF_W:0]   half_inc;
  logic [7:0]        sout_ld;

  always_comb begin
    idle_lvl = cfg.spi_mode[1];
    phase1   = cfg.spi_mode[0];
    limit    = (cfg.half_period_ticks == '0) ? (DIV_W + 1)'(1)
                                             : {1'b0, cfg.half_period_ticks};
    div_inc  = {1'b0, div_r} + (DIV_W + 1)'(1);
    sub_inc  = {1'b0, sub_r} + (SUB_W + 1)'(1);
    half_inc = {1'b0, half_r} + (HALF_W + 1)'(1);
    sout_ld  = item.tx_present ? item.tx_byte : TX_FILL;

    div_nxt      = div_r;
    half_nxt     = half_r;
    sout_nxt     = sout_r;
    sin_nxt      = sin_r;
    shifting_nxt = shifting_r;
    clk_lvl_nxt  = clk_lvl_r;
    dat_lvl_nxt  = dat_lvl_r;
    ending_nxt   = ending_r;
    aborted_nxt  = aborted_r;
    sub_nxt      = sub_r;
    ms_nxt       = ms_r;
    xfers_nxt    = xfers_r;
    errs_nxt     = errs_r;

    res               = '0;

    if (item.mode == OP_LOAD) begin
      if (shifting_r || (aborted_r && !item.first_byte)) begin
        res.load_rejected = 1'b1;
      end else begin
        if (item.first_byte) begin
          sub_nxt     = '0;
          ms_nxt      = '0;
          aborted_nxt = 1'b0;
        end
        sout_nxt     = sout_ld;
        sin_nxt      = '0;
        shifting_nxt = 1'b1;
        half_nxt     = '0;
        div_nxt      = '0;
        ending_nxt   = item.last_byte;
        clk_lvl_nxt  = idle_lvl;
        if (!phase1) dat_lvl_nxt = sout_ld[7];
      end
    end else begin
      // millisecond timer: advanced by tick items, saturates at MS_MAX
      if (sub_inc >= SUB_LIM) begin
        sub_nxt = '0;
        if (ms_r != MS_MAX) ms_nxt = ms_r + TMO_W'(1);
      end else begin
        sub_nxt = sub_inc[SUB_W-1:0];
      end

      if (shifting_r) begin
        if (div_inc >= limit) begin
          div_nxt = '0;
          if (!half_r[0]) begin
            clk_lvl_nxt = ~idle_lvl;
            if (phase1) dat_lvl_nxt = sout_r[7];
            else        sin_nxt     = {sin_r[6:0], item.miso};
          end else begin
            clk_lvl_nxt = idle_lvl;
            if (phase1) sin_nxt = {sin_r[6:0], item.miso};
            sout_nxt = {sout_r[6:0], 1'b0};
            if (!phase1 && half_inc < (HALF_W + 1)'(HALF_CNT)) dat_lvl_nxt = sout_r[6];
          end
          if (half_inc >= (HALF_W + 1)'(HALF_CNT)) begin
            half_nxt     = '0;
            shifting_nxt = 1'b0;
            res.rx_valid = 1'b1;
            res.rx_byte  = sin_nxt;
            if (ms_nxt >= cfg.abort_ms) begin
              res.timed_out     = 1'b1;
              res.transfer_done = 1'b1;
              aborted_nxt       = 1'b1;
              xfers_nxt         = xfers_r + CNT_W'(1);
              errs_nxt          = errs_r + CNT_W'(1);
            end else if (ending_r) begin
              res.transfer_done = 1'b1;
              xfers_nxt         = xfers_r + CNT_W'(1);
            end
          end else begin
            half_nxt = half_inc[HALF_W-1:0];
          end
        end else begin
          div_nxt = div_inc[DIV_W-1:0];
        end
      end
    end

    res.sck       = clk_lvl_nxt;
    res.mosi      = dat_lvl_nxt;
    res.busy_res  = shifting_nxt;
    res.transfers = xfers_nxt;
    res.errors    = errs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r      <= '0;
      half_r     <= '0;
      sout_r     <= '0;
      sin_r      <= '0;
      shifting_r <= 1'b0;
      clk_lvl_r  <= 1'b0;
      dat_lvl_r  <= 1'b0;
      ending_r   <= 1'b0;
      aborted_r  <= 1'b0;
      sub_r      <= '0;
      ms_r       <= '0;
      xfers_r    <= '0;
      errs_r     <= '0;
    end else if (step) begin
      div_r      <= div_nxt;
      half_r     <= half_nxt;
      sout_r     <= sout_nxt;
      sin_r      <= sin_nxt;
      shifting_r <= shifting_nxt;
      clk_lvl_r  <= clk_lvl_nxt;
      dat_lvl_r  <= dat_lvl_nxt;
      ending_r   <= ending_nxt;
      aborted_r  <= aborted_nxt;
      sub_r      <= sub_nxt;
      ms_r       <= ms_nxt;
      xfers_r    <= xfers_nxt;
      errs_r     <= errs_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/spi_master_byte_transceiver_top.sv
// Top level of the SPI master byte transceiver: config registers, input
// register, core and result register. Depends on smbt_pkg, smbt_if, smbt_core.
//
//   channel  dir  handshake            content
//   in_if    in   valid/ready          load or microsecond tick item
//   out_if   out  valid/ready          pin levels, rx byte, status, counters
//   cfg_*    in   write enable only    spi_mode, half period, abort limit
//
// An accepted item passes through the input register and one pass of the core
// into the result register; one item per cycle sustained while out_if is ready.
// Reset is synchronous and clears core state, counters and config to defaults.
// While a result waits on out_if, one more item is taken into the input register.
`default_nettype none
module spi_master_byte_transceiver_top #(
  parameter int unsigned TICKS_PER_MS = smbt_pkg::TICKS_PER_MS_D
) (
  input  wire                               clk,
  input  wire                               rst_n,
  smbt_in_if.sink                           in_if,
  smbt_out_if.source                        out_if,
  input  wire                               cfg_we,
  input  wire [smbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [smbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import smbt_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_item_r;
  logic      in_full_r;
  out_item_t out_item_r;
  logic      out_full_r;
  out_item_t core_res;
  in_item_t  in_item;
  logic      step;

  assign step = in_full_r && (!out_full_r || out_if.ready);
  assign in_if.ready = !in_full_r || step;

  always_comb begin
    in_item.mode       = in_if.mode;
    in_item.tx_byte    = in_if.tx_byte;
    in_item.tx_present = in_if.tx_present;
    in_item.first_byte = in_if.first_byte;
    in_item.last_byte  = in_if.last_byte;
    in_item.miso       = in_if.miso;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spi_mode          <= '0;
      cfg_r.half_period_ticks <= DIV_W'(1);
      cfg_r.abort_ms          <= TMO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPI_MODE: cfg_r.spi_mode          <= cfg_data[1:0];
        CFG_HALF_PER: cfg_r.half_period_ticks <= cfg_data[DIV_W-1:0];
        CFG_TIMEOUT:  cfg_r.abort_ms          <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      if (in_if.ready) in_full_r <= in_if.valid;
      if (step) out_full_r <= 1'b1;
      else if (out_if.ready) out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) in_item_r <= in_item;
    if (step) out_item_r <= core_res;
  end

  smbt_core #(
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_if.valid         = out_full_r;
  assign out_if.sck           = out_item_r.sck;
  assign out_if.mosi          = out_item_r.mosi;
  assign out_if.rx_byte       = out_item_r.rx_byte;
  assign out_if.rx_valid      = out_item_r.rx_valid;
  assign out_if.transfer_done = out_item_r.transfer_done;
  assign out_if.timed_out     = out_item_r.timed_out;
  assign out_if.busy_res      = out_item_r.busy_res;
  assign out_if.load_rejected = out_item_r.load_rejected;
  assign out_if.transfers     = out_item_r.transfers;
  assign out_if.errors        = out_item_r.errors;

endmodule
`default_nettype wire
